FILE: design/tglos_pkg.sv
// Shared constants for the tile grid line of sight unit.
// No dependencies.
package tglos_pkg;

  localparam int TILE_PIXELS = 128;
  localparam int MAX_TILES   = 4096;

  localparam int TP_SH   = $clog2(TILE_PIXELS);
  localparam int TQ8_SH  = TP_SH + 8;
  localparam int TQ16_SH = TP_SH + 16;
  localparam int TQ24_SH = TP_SH + 24;
  localparam int ADDR_W  = $clog2(MAX_TILES);

  localparam int PT_W   = 21;
  localparam int CRN_W  = 14;
  localparam int TILE_W = 6;
  localparam int GRID_W = 7;
  localparam int IDX_W  = 17;
  localparam int ACC_W  = 64;
  localparam int ALU_W  = ACC_W + 1;
  localparam int DIV_W  = 48;
  localparam int MAG_W  = 38;
  localparam int R_W    = MAG_W + 1;
  localparam int D_W    = PT_W + 1;
  localparam int E_W    = PT_W + 2;
  localparam int CNT_W  = 6;
  localparam int DIV_N  = DIV_W;
  localparam int MUL_N  = E_W;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  localparam logic [GRID_W-1:0] GRID_RESET = 7'd64;

endpackage

FILE: design/tile_grid_line_of_sight_unit.sv
// Tile grid line of sight: solid tile bitmap plus iterative visibility walk.
// Depends on tglos_pkg and tglos_ram.
// Write item: stored if it lies inside the grid. Query item: a slope division, the
// first intercept product, a check per column crossed, and with rows to cross two
// more divisions then a check per row; the result is then presented.
// One item at a time; the iterative arithmetic goes through one shared 65-bit adder.
// Reset: grid registers to 64, then a clearing pass over all MAX_TILES (4096) entries
// of the tile memory during which no item is taken.
module tile_grid_line_of_sight_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_func,
  input  logic [tglos_pkg::TILE_W-1:0]  in_tile_col,
  input  logic [tglos_pkg::TILE_W-1:0]  in_tile_row,
  input  logic                          in_tile_solid,
  input  logic [tglos_pkg::PT_W-1:0]    in_src_x,
  input  logic [tglos_pkg::PT_W-1:0]    in_src_y,
  input  logic [tglos_pkg::CRN_W-1:0]   in_corner_x,
  input  logic [tglos_pkg::CRN_W-1:0]   in_corner_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_visible,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tglos_pkg::APB_AW-1:0]  paddr,
  input  logic [tglos_pkg::APB_DW-1:0]  pwdata,
  output logic [tglos_pkg::APB_DW-1:0]  prdata,
  output logic                          pready
);
  import tglos_pkg::*;

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_DIV   = 5'd2;
  localparam logic [4:0] S_VSET  = 5'd3;
  localparam logic [4:0] S_MUL   = 5'd4;
  localparam logic [4:0] S_VINIT = 5'd5;
  localparam logic [4:0] S_VCHK  = 5'd6;
  localparam logic [4:0] S_VWAIT = 5'd7;
  localparam logic [4:0] S_HSET  = 5'd8;
  localparam logic [4:0] S_HA    = 5'd9;
  localparam logic [4:0] S_HB    = 5'd10;
  localparam logic [4:0] S_HC    = 5'd11;
  localparam logic [4:0] S_HPX   = 5'd12;
  localparam logic [4:0] S_HL    = 5'd13;
  localparam logic [4:0] S_HLW   = 5'd14;
  localparam logic [4:0] S_HT    = 5'd15;
  localparam logic [4:0] S_HTW   = 5'd16;
  localparam logic [4:0] S_FIN   = 5'd17;

  localparam logic [1:0] K_M  = 2'd0;
  localparam logic [1:0] K_Q0 = 2'd1;
  localparam logic [1:0] K_QD = 2'd2;

  logic [4:0]        state_r, state_nxt;
  logic [1:0]        kind_r, kind_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [GRID_W-1:0] gw_r, gh_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_vis_r, out_vis_nxt;
  logic              vis_r, vis_nxt;

  logic [PT_W-1:0]   sx_r, sx_nxt, sy_r, sy_nxt;
  logic [CRN_W-1:0]  cx_r, cx_nxt, cy_r, cy_nxt;
  logic              vert_r, vert_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [DIV_W-1:0]  num_r, num_nxt;
  logic [ACC_W-1:0]  mc_r, mc_nxt;
  logic [MAG_W-1:0]  den_r, den_nxt;
  logic [MAG_W-1:0]  m_mag_r, m_mag_nxt;
  logic              m_neg_r, m_neg_nxt;
  logic              eneg_r, eneg_nxt;
  logic [DIV_W-1:0]  q_r, q_nxt, qd_r, qd_nxt;
  logic [R_W-1:0]    r_r, r_nxt, rd_r, rd_nxt;
  logic              cbit_r, cbit_nxt;
  logic [GRID_W-1:0] cc_r, cc_nxt, cr_r, cr_nxt;

  // shared adder
  logic [ALU_W-1:0]  alu_a, alu_b, alu_y;
  logic              alu_sub, alu_ci;

  assign alu_y = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub | alu_ci);

  // geometry derived from the latched item
  logic [GRID_W-1:0] scol, dcol, srow, drow, cc0, cr0;
  logic              desc_v, desc_h, qneg;
  logic [E_W-1:0]    e_base, sx_e;
  logic              eneg;
  logic [E_W-1:0]    emag;
  logic [D_W-1:0]    hbase, sy_e, hmag;

  assign scol   = GRID_W'(sx_r >> TQ8_SH);
  assign srow   = GRID_W'(sy_r >> TQ8_SH);
  assign dcol   = GRID_W'(cx_r >> TP_SH);
  assign drow   = GRID_W'(cy_r >> TP_SH);
  assign desc_v = dcol < scol;
  assign desc_h = drow < srow;
  assign cc0    = (dcol > scol) ? scol + GRID_W'(1) : scol;
  assign cr0    = (drow > srow) ? srow + GRID_W'(1) : srow;
  assign qneg   = desc_h ^ m_neg_r;
  assign e_base = E_W'(cc0) << TQ8_SH;
  assign sx_e   = E_W'(sx_r);
  assign eneg   = e_base < sx_e;
  assign emag   = eneg ? sx_e - e_base : e_base - sx_e;
  assign hbase  = D_W'(cr0) << TQ8_SH;
  assign sy_e   = D_W'(sy_r);
  assign hmag   = desc_h ? sy_e - hbase : hbase - sy_e;

  // query set-up from the input ports
  logic [D_W-1:0]    dx_in, dy_in, xmag_in, ymag_in;
  logic              xlt_in, ylt_in;

  assign dx_in   = {in_corner_x, 8'd0};
  assign dy_in   = {in_corner_y, 8'd0};
  assign xlt_in  = D_W'(in_src_x) < dx_in;
  assign ylt_in  = D_W'(in_src_y) < dy_in;
  assign xmag_in = xlt_in ? dx_in - D_W'(in_src_x) : D_W'(in_src_x) - dx_in;
  assign ymag_in = ylt_in ? dy_in - D_W'(in_src_y) : D_W'(in_src_y) - dy_in;

  // crossing decode from the accumulator
  logic              v_row_ok, px_neg, h_col_ok, h_edge;
  logic [GRID_W-1:0] v_row, v_col, h_col, h_row;

  assign v_row_ok = acc_r[ACC_W-1]
                    ? (&acc_r[ACC_W-1:TQ24_SH] && |acc_r[TQ24_SH-1:0])
                    : (acc_r[ACC_W-2:TQ24_SH+GRID_W] == '0);
  assign v_row    = acc_r[ACC_W-1] ? '0 : GRID_W'(acc_r >> TQ24_SH);
  assign v_col    = desc_v ? cc_r - GRID_W'(1) : cc_r;
  assign px_neg   = acc_r[ACC_W-1];
  assign h_col    = px_neg ? '0 : GRID_W'(acc_r >> TQ16_SH);
  assign h_col_ok = (px_neg ? (&acc_r[ACC_W-1:TQ16_SH] && |acc_r[TQ16_SH-1:0])
                            : (acc_r[ACC_W-2:TQ16_SH+GRID_W] == '0))
                    && (h_col < gw_r);
  assign h_edge   = !px_neg && (acc_r[TQ16_SH-1:16] == '0) && (h_col != '0);
  assign h_row    = desc_h ? cr_r - GRID_W'(1) : cr_r;

  // tile address check
  logic [GRID_W-1:0] tc_col, tc_row;
  logic [IDX_W-1:0]  tc_idx;
  logic              tc_ok;

  always_comb begin
    case (state_r)
      S_IDLE: begin
        tc_col = GRID_W'(in_tile_col);
        tc_row = GRID_W'(in_tile_row);
      end
      S_VCHK: begin
        tc_col = v_col;
        tc_row = v_row;
      end
      S_HL: begin
        tc_col = h_col - GRID_W'(1);
        tc_row = h_row;
      end
      S_HT: begin
        tc_col = h_col;
        tc_row = h_row;
      end
      default: begin
        tc_col = '0;
        tc_row = '0;
      end
    endcase
  end

  assign tc_idx = IDX_W'(tc_row) * IDX_W'(gw_r) + IDX_W'(tc_col);
  assign tc_ok  = (tc_col < gw_r) && (tc_row < gh_r) && (tc_idx < IDX_W'(MAX_TILES));

  // tile memory
  logic              ram_we, ram_wdata, ram_rdata;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;

  assign ram_we    = (state_r == S_CLR) ||
                     ((state_r == S_IDLE) && in_valid && (in_func == FUNC_WRITE) && tc_ok);
  assign ram_waddr = (state_r == S_CLR) ? clr_r : ADDR_W'(tc_idx);
  assign ram_wdata = (state_r == S_CLR) ? 1'b0 : in_tile_solid;
  assign ram_raddr = ADDR_W'(tc_idx);

  tglos_ram #(.WIDTH(1), .DEPTH(MAX_TILES)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // adder operands
  logic [ACC_W-1:0] div_trial;

  assign div_trial = {acc_r[ACC_W-2:0], num_r[DIV_W-1]};

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    alu_ci  = 1'b0;
    case (state_r)
      S_DIV: begin
        alu_a   = ALU_W'(div_trial);
        alu_b   = ALU_W'(den_r);
        alu_sub = 1'b1;
      end
      S_MUL: begin
        alu_a = ALU_W'(acc_r);
        alu_b = ALU_W'(mc_r);
      end
      S_VINIT: begin
        alu_a   = ALU_W'({sy_r, 16'd0});
        alu_b   = {acc_r[ACC_W-1], acc_r};
        alu_sub = eneg_r ^ m_neg_r;
      end
      S_VCHK, S_VWAIT: begin
        alu_a   = {acc_r[ACC_W-1], acc_r};
        alu_b   = ALU_W'(m_mag_r) << TQ8_SH;
        alu_sub = m_neg_r ^ desc_v;
      end
      S_HA: begin
        alu_a = ALU_W'(r_r);
        alu_b = ALU_W'(rd_r);
      end
      S_HB: begin
        alu_a   = ALU_W'(r_r);
        alu_b   = ALU_W'(m_mag_r);
        alu_sub = 1'b1;
      end
      S_HC: begin
        alu_a  = ALU_W'(q_r);
        alu_b  = ALU_W'(qd_r);
        alu_ci = cbit_r;
      end
      S_HPX: begin
        alu_a   = ALU_W'({sx_r, 8'd0});
        alu_b   = ALU_W'(q_r);
        alu_sub = qneg;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  // sequencer
  logic             div_ge;
  logic [ACC_W-1:0] div_rem;
  logic [DIV_W-1:0] div_q;
  logic [GRID_W-1:0] cc_step, cr_step;

  assign div_ge  = !alu_y[ALU_W-1];
  assign div_rem = div_ge ? alu_y[ACC_W-1:0] : div_trial;
  assign div_q   = {num_r[DIV_W-2:0], div_ge};
  assign cc_step = desc_v ? cc_r - GRID_W'(1) : cc_r + GRID_W'(1);
  assign cr_step = desc_h ? cr_r - GRID_W'(1) : cr_r + GRID_W'(1);

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    cnt_nxt       = cnt_r;
    clr_nxt       = clr_r;
    vis_nxt       = vis_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_vis_nxt   = out_vis_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    vert_nxt      = vert_r;
    acc_nxt       = acc_r;
    num_nxt       = num_r;
    mc_nxt        = mc_r;
    den_nxt       = den_r;
    m_mag_nxt     = m_mag_r;
    m_neg_nxt     = m_neg_r;
    eneg_nxt      = eneg_r;
    q_nxt         = q_r;
    qd_nxt        = qd_r;
    r_nxt         = r_r;
    rd_nxt        = rd_r;
    cbit_nxt      = cbit_r;
    cc_nxt        = cc_r;
    cr_nxt        = cr_r;

    case (state_r)
      S_CLR: begin
        clr_nxt = clr_r + ADDR_W'(1);
        if (clr_r == ADDR_W'(MAX_TILES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && (in_func == FUNC_QUERY)) begin
          sx_nxt    = in_src_x;
          sy_nxt    = in_src_y;
          cx_nxt    = in_corner_x;
          cy_nxt    = in_corner_y;
          vert_nxt  = (xmag_in == '0);
          m_mag_nxt = '0;
          m_neg_nxt = xlt_in ^ ylt_in;
          acc_nxt   = '0;
          num_nxt   = DIV_W'({ymag_in, 16'd0});
          den_nxt   = MAG_W'(xmag_in);
          cnt_nxt   = '0;
          kind_nxt  = K_M;
          state_nxt = (xmag_in == '0) ? S_VSET : S_DIV;
        end
      end
      S_DIV: begin
        acc_nxt = div_rem;
        num_nxt = div_q;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_N - 1)) begin
          case (kind_r)
            K_M: begin
              m_mag_nxt = MAG_W'(div_q);
              m_neg_nxt = m_neg_r && (div_q != '0);
              state_nxt = S_VSET;
            end
            K_Q0: begin
              q_nxt    = div_q;
              r_nxt    = R_W'(div_rem);
              acc_nxt  = '0;
              num_nxt  = DIV_W'(1) << (TP_SH + 32);
              den_nxt  = m_mag_r;
              cnt_nxt  = '0;
              kind_nxt = K_QD;
            end
            default: begin
              qd_nxt    = div_q;
              rd_nxt    = R_W'(div_rem);
              state_nxt = S_HPX;
            end
          endcase
        end
      end
      S_VSET: begin
        cc_nxt = cc0;
        if (cc0 == dcol) begin
          state_nxt = S_HSET;
        end else begin
          acc_nxt   = '0;
          mc_nxt    = ACC_W'(m_mag_r);
          num_nxt   = DIV_W'(emag);
          eneg_nxt  = eneg;
          cnt_nxt   = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (num_r[0]) begin
          acc_nxt = alu_y[ACC_W-1:0];
        end
        mc_nxt  = mc_r << 1;
        num_nxt = num_r >> 1;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(MUL_N - 1)) begin
          state_nxt = S_VINIT;
        end
      end
      S_VINIT: begin
        acc_nxt   = alu_y[ACC_W-1:0];
        state_nxt = S_VCHK;
      end
      S_VCHK, S_VWAIT: begin
        if ((state_r == S_VCHK) && v_row_ok && tc_ok) begin
          state_nxt = S_VWAIT;
        end else if ((state_r == S_VWAIT) && ram_rdata) begin
          vis_nxt   = 1'b0;
          state_nxt = S_FIN;
        end else begin
          acc_nxt   = alu_y[ACC_W-1:0];
          cc_nxt    = cc_step;
          state_nxt = (cc_step == dcol) ? S_HSET : S_VCHK;
        end
      end
      S_HSET: begin
        cr_nxt = cr0;
        if (cr0 == drow) begin
          vis_nxt   = 1'b1;
          state_nxt = S_FIN;
        end else if (vert_r) begin
          q_nxt     = '0;
          state_nxt = S_HPX;
        end else if (m_mag_r == '0) begin
          vis_nxt   = 1'b1;
          state_nxt = S_FIN;
        end else begin
          acc_nxt   = '0;
          num_nxt   = DIV_W'(hmag) << 24;
          den_nxt   = m_mag_r;
          cnt_nxt   = '0;
          kind_nxt  = K_Q0;
          state_nxt = S_DIV;
        end
      end
      S_HA: begin
        r_nxt     = R_W'(alu_y);
        state_nxt = S_HB;
      end
      S_HB: begin
        cbit_nxt = !alu_y[ALU_W-1];
        if (!alu_y[ALU_W-1]) begin
          r_nxt = R_W'(alu_y);
        end
        state_nxt = S_HC;
      end
      S_HC: begin
        q_nxt     = DIV_W'(alu_y);
        state_nxt = S_HPX;
      end
      S_HPX: begin
        acc_nxt   = alu_y[ACC_W-1:0];
        state_nxt = S_HL;
      end
      S_HL, S_HLW, S_HT, S_HTW: begin
        if (((state_r == S_HLW) || (state_r == S_HTW)) && ram_rdata) begin
          vis_nxt   = 1'b0;
          state_nxt = S_FIN;
        end else if ((state_r == S_HL) && h_col_ok && h_edge && tc_ok) begin
          state_nxt = S_HLW;
        end else if ((state_r == S_HL) || (state_r == S_HLW)) begin
          state_nxt = S_HT;
        end else if ((state_r == S_HT) && h_col_ok && tc_ok) begin
          state_nxt = S_HTW;
        end else begin
          cr_nxt = cr_step;
          if (cr_step == drow) begin
            vis_nxt   = 1'b1;
            state_nxt = S_FIN;
          end else begin
            state_nxt = vert_r ? S_HPX : S_HA;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_vis_nxt   = vis_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      cnt_r       <= '0;
      kind_r      <= K_M;
      out_valid_r <= 1'b0;
      gw_r        <= GRID_RESET;
      gh_r        <= GRID_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      kind_r      <= kind_nxt;
      out_valid_r <= out_valid_nxt;
      if (psel && penable && pwrite) begin
        if (paddr[2] == REG_GRID_HEIGHT) begin
          gh_r <= pwdata[GRID_W-1:0];
        end else begin
          gw_r <= pwdata[GRID_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_vis_r <= out_vis_nxt;
    vis_r     <= vis_nxt;
    sx_r      <= sx_nxt;
    sy_r      <= sy_nxt;
    cx_r      <= cx_nxt;
    cy_r      <= cy_nxt;
    vert_r    <= vert_nxt;
    acc_r     <= acc_nxt;
    num_r     <= num_nxt;
    mc_r      <= mc_nxt;
    den_r     <= den_nxt;
    m_mag_r   <= m_mag_nxt;
    m_neg_r   <= m_neg_nxt;
    eneg_r    <= eneg_nxt;
    q_r       <= q_nxt;
    qd_r      <= qd_nxt;
    r_r       <= r_nxt;
    rd_r      <= rd_nxt;
    cbit_r    <= cbit_nxt;
    cc_r      <= cc_nxt;
    cr_r      <= cr_nxt;
  end

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_visible = out_vis_r;
  assign pready      = 1'b1;
  assign prdata      = (paddr[2] == REG_GRID_HEIGHT) ? APB_DW'(gh_r) : APB_DW'(gw_r);

endmodule

FILE: design/tglos_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tglos_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/tglos_chk.sv
// Port-level checks for the tile grid line of sight unit, bound to the top level.
// Depends on tglos_pkg.
module tglos_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_func,
  input logic [tglos_pkg::TILE_W-1:0]  in_tile_col,
  input logic [tglos_pkg::TILE_W-1:0]  in_tile_row,
  input logic                          in_tile_solid,
  input logic [tglos_pkg::PT_W-1:0]    in_src_x,
  input logic [tglos_pkg::PT_W-1:0]    in_src_y,
  input logic [tglos_pkg::CRN_W-1:0]   in_corner_x,
  input logic [tglos_pkg::CRN_W-1:0]   in_corner_y,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_visible,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [tglos_pkg::APB_AW-1:0]  paddr,
  input logic [tglos_pkg::APB_DW-1:0]  pwdata,
  input logic [tglos_pkg::APB_DW-1:0]  prdata,
  input logic                          pready
);
  import tglos_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_visible))
    else $error("result item dropped or changed while stalled");

  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == FUNC_WRITE) |=> !$rose(out_valid))
    else $error("tile write produced a result item");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == FUNC_QUERY) |=> !in_ready)
    else $error("ready straight after a query item");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind tile_grid_line_of_sight_unit tglos_chk u_tglos_chk (.*);
